// ===== design/tri_pkg.sv =====
package tri_pkg;

    localparam int COORD_W       = 32;
    localparam int DIST_W        = 31;
    localparam int TOL_W         = 16;
    localparam int FRAC_BITS_DEF = 8;
    localparam logic [TOL_W-1:0] TOL_RESET = 16'd3;

    // quotient bits produced by the divider, one per stage
    localparam int DIV_STEPS = 32;

    typedef logic signed [COORD_W-1:0] t_coord;
    typedef logic        [DIST_W-1:0]  t_dist;
    typedef logic        [TOL_W-1:0]   t_tol;

endpackage

// ===== design/three_circle_trilateration.sv =====
// three-anchor 2d trilateration, fully pipelined
//
// input channel (i_in_valid / o_in_ready): one beat carries three anchors, each
// with x, y (signed) and horizontal distance (unsigned), all fixed point with
// FRAC_BITS fraction bits. output channel (o_out_valid / i_out_ready): one beat
// per input beat, in order: o_found and the target position, rounded to
// nearest (ties away from zero) and saturated to 32 bits; zero when not found.
// config channel (i_cfg_valid / o_cfg_ready): writes the equality tolerance;
// always ready, write it only while the pipeline is empty.
//
// throughput: one beat per cycle while the skid spare is empty. pipeline from input
// accept to the output: 8 datapath stages, one overflow-check stage, a 32-stage
// restoring divider (one quotient bit per stage, two 101-bit compare/subtracts
// each, for x and y), a rounding stage and the output register.
// stall: the pipeline feeds a two-entry skid (output register plus spare).
// while the spare is empty the pipeline moves and input is taken even if the
// receiver is stalled; once the spare fills, the whole pipeline freezes and
// o_in_ready drops, both driven straight from the spare's valid flop.
// reset: synchronous, clears all valid bits and loads the tolerance to 3
module three_circle_trilateration
    import tri_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_cfg_valid,
    output logic   o_cfg_ready,
    input  t_tol   i_cfg_data,
    input  logic   i_in_valid,
    output logic   o_in_ready,
    input  t_coord i_anchor0_x,
    input  t_coord i_anchor0_y,
    input  t_dist  i_anchor0_dist,
    input  t_coord i_anchor1_x,
    input  t_coord i_anchor1_y,
    input  t_dist  i_anchor1_dist,
    input  t_coord i_anchor2_x,
    input  t_coord i_anchor2_y,
    input  t_dist  i_anchor2_dist,
    output logic   o_out_valid,
    input  logic   i_out_ready,
    output logic   o_found,
    output t_coord o_target_x,
    output t_coord o_target_y
);

    // datapath widths
    localparam int DF_W   = COORD_W + 1;          // coordinate difference
    localparam int SQ_W   = 2 * COORD_W;          // coordinate square
    localparam int RR_W   = 2 * DIST_W;           // distance square
    localparam int S_W    = SQ_W + 2;             // x*x + y*y - r*r
    localparam int PP_W   = 2 * DF_W;             // difference products
    localparam int DET_W  = PP_W + 1;
    localparam int LO_W   = DF_W;                 // low slice of a circle term
    localparam int PL_W   = DF_W + LO_W + 1;
    localparam int PH_W   = DF_W + (S_W - LO_W);
    localparam int P_W    = 100;                  // full line-term product
    localparam int N_W    = P_W + 1;              // numerator
    localparam int D_W    = DET_W + 1;            // denominator 2*det
    localparam int TP_W   = TOL_W + PP_W;
    localparam int LHS_W  = DET_W + FRAC_BITS;
    localparam int CMP_W  = (LHS_W > TP_W) ? LHS_W : TP_W;
    localparam int Q_W    = DIV_STEPS;

    typedef enum logic [1:0] {REF_A0, REF_A1, REF_A2} t_ref;

    typedef struct packed {
        logic found;
        logic neg_x;
        logic neg_y;
        logic ovf_x;
        logic ovf_y;
        logic [D_W-1:0] den;
    } t_side;

    typedef struct packed {
        logic   found;
        t_coord x;
        t_coord y;
    } t_res;

    // saturate a rounded magnitude quotient and apply its sign, giving a signed 32-bit value
    function automatic t_coord sat_q(input logic [Q_W:0] q, input logic neg,
                                     input logic ovf);
        logic [Q_W:0] lim;
        logic [Q_W:0] m;
        begin
            lim = neg ? (Q_W+1)'(33'h0_8000_0000) : (Q_W+1)'(33'h0_7FFF_FFFF);
            m   = (ovf || (q > lim)) ? lim : q;
            sat_q = neg ? COORD_W'(-m) : COORD_W'(m);
        end
    endfunction

    // --------------------------------------------------------------------
    // config register and global advance
    t_tol r_tol;
    logic r_spare_vld;
    logic en;

    assign o_cfg_ready = 1'b1;
    assign en          = !r_spare_vld;
    assign o_in_ready  = en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tol <= TOL_RESET;
        end else if (i_cfg_valid) begin
            r_tol <= i_cfg_data;
        end
    end

    // --------------------------------------------------------------------
    // stage 1: capture the beat
    logic   r1_vld;
    t_coord r1_x [3];
    t_coord r1_y [3];
    t_dist  r1_d [3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
        end else if (en) begin
            r1_vld <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r1_x[0] <= i_anchor0_x;
            r1_y[0] <= i_anchor0_y;
            r1_d[0] <= i_anchor0_dist;
            r1_x[1] <= i_anchor1_x;
            r1_y[1] <= i_anchor1_y;
            r1_d[1] <= i_anchor1_dist;
            r1_x[2] <= i_anchor2_x;
            r1_y[2] <= i_anchor2_y;
            r1_d[2] <= i_anchor2_dist;
        end
    end

    // --------------------------------------------------------------------
    // stage 2: x closeness tests and squares
    logic signed [DF_W-1:0] d01, d02;
    logic        [DF_W-1:0] m01, m02;
    logic r2_vld, r2_n01, r2_n02;
    logic [SQ_W-1:0] r2_xx [3];
    logic [SQ_W-1:0] r2_yy [3];
    logic [RR_W-1:0] r2_rr [3];
    t_coord r2_x [3];
    t_coord r2_y [3];

    assign d01 = DF_W'(r1_x[0]) - DF_W'(r1_x[1]);
    assign d02 = DF_W'(r1_x[0]) - DF_W'(r1_x[2]);
    assign m01 = d01[DF_W-1] ? DF_W'(-d01) : DF_W'(d01);
    assign m02 = d02[DF_W-1] ? DF_W'(-d02) : DF_W'(d02);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_vld <= 1'b0;
        end else if (en) begin
            r2_vld <= r1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r2_n01 <= m01 < DF_W'(r_tol);
            r2_n02 <= m02 < DF_W'(r_tol);
            for (int i = 0; i < 3; i++) begin
                r2_xx[i] <= SQ_W'(r1_x[i] * r1_x[i]);
                r2_yy[i] <= SQ_W'(r1_y[i] * r1_y[i]);
                r2_rr[i] <= RR_W'(r1_d[i] * r1_d[i]);
                r2_x[i]  <= r1_x[i];
                r2_y[i]  <= r1_y[i];
            end
        end
    end

    // --------------------------------------------------------------------
    // stage 3: circle terms, reference choice, line coefficients
    logic signed [S_W-1:0] s [3];
    t_ref sel;
    t_coord xr, yr, xj, yj, xk, yk;
    logic signed [S_W-1:0] sr, sj, sk;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            s[i] = $signed(S_W'(r2_xx[i])) + $signed(S_W'(r2_yy[i]))
                 - $signed(S_W'(r2_rr[i]));
        end
        if (!r2_n01 && !r2_n02) begin
            sel = REF_A0;
        end else if (r2_n01) begin
            sel = REF_A2;
        end else begin
            sel = REF_A1;
        end
        case (sel)
            REF_A2: begin
                xr = r2_x[2]; yr = r2_y[2]; sr = s[2];
                xj = r2_x[1]; yj = r2_y[1]; sj = s[1];
                xk = r2_x[0]; yk = r2_y[0]; sk = s[0];
            end
            REF_A1: begin
                xr = r2_x[1]; yr = r2_y[1]; sr = s[1];
                xj = r2_x[0]; yj = r2_y[0]; sj = s[0];
                xk = r2_x[2]; yk = r2_y[2]; sk = s[2];
            end
            default: begin
                xr = r2_x[0]; yr = r2_y[0]; sr = s[0];
                xj = r2_x[1]; yj = r2_y[1]; sj = s[1];
                xk = r2_x[2]; yk = r2_y[2]; sk = s[2];
            end
        endcase
    end

    logic r3_vld, r3_allx;
    logic signed [DF_W-1:0] r3_aj, r3_bj, r3_ak, r3_bk;
    logic signed [S_W-1:0]  r3_sr, r3_sj, r3_sk;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_vld <= 1'b0;
        end else if (en) begin
            r3_vld <= r2_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r3_allx <= r2_n01 && r2_n02;
            r3_aj   <= DF_W'(xr) - DF_W'(xj);
            r3_bj   <= DF_W'(yr) - DF_W'(yj);
            r3_ak   <= DF_W'(xr) - DF_W'(xk);
            r3_bk   <= DF_W'(yr) - DF_W'(yk);
            r3_sr   <= sr;
            r3_sj   <= sj;
            r3_sk   <= sk;
        end
    end

    // --------------------------------------------------------------------
    // stage 4: right-hand sides and coefficient products
    logic r4_vld, r4_allx, r4_zero;
    logic signed [DF_W-1:0] r4_aj, r4_bj, r4_ak, r4_bk;
    logic signed [S_W-1:0]  r4_cj, r4_ck;
    logic signed [PP_W-1:0] r4_ajbk, r4_akbj, r4_ajak;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r4_vld <= 1'b0;
        end else if (en) begin
            r4_vld <= r3_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r4_allx <= r3_allx;
            r4_zero <= (r3_aj == '0) || (r3_ak == '0);
            r4_aj   <= r3_aj;
            r4_bj   <= r3_bj;
            r4_ak   <= r3_ak;
            r4_bk   <= r3_bk;
            r4_cj   <= r3_sr - r3_sj;
            r4_ck   <= r3_sr - r3_sk;
            r4_ajbk <= PP_W'(r3_aj * r3_bk);
            r4_akbj <= PP_W'(r3_ak * r3_bj);
            r4_ajak <= PP_W'(r3_aj * r3_ak);
        end
    end

    // --------------------------------------------------------------------
    // stage 5: determinant and split products for the numerators
    // circle terms split as hi * 2^LO_W + lo, lo unsigned
    logic signed [LO_W:0]       cj_lo, ck_lo;
    logic signed [S_W-LO_W-1:0] cj_hi, ck_hi;

    assign cj_lo = $signed({1'b0, r4_cj[LO_W-1:0]});
    assign ck_lo = $signed({1'b0, r4_ck[LO_W-1:0]});
    assign cj_hi = r4_cj[S_W-1:LO_W];
    assign ck_hi = r4_ck[S_W-1:LO_W];

    logic r5_vld, r5_allx, r5_zero;
    logic signed [DET_W-1:0] r5_det;
    logic signed [PP_W-1:0]  r5_ajak;
    logic signed [PL_W-1:0]  r5_l_ajck, r5_l_akcj, r5_l_cjbk, r5_l_ckbj;
    logic signed [PH_W-1:0]  r5_h_ajck, r5_h_akcj, r5_h_cjbk, r5_h_ckbj;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r5_vld <= 1'b0;
        end else if (en) begin
            r5_vld <= r4_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r5_allx   <= r4_allx;
            r5_zero   <= r4_zero;
            r5_det    <= DET_W'(r4_ajbk) - DET_W'(r4_akbj);
            r5_ajak   <= r4_ajak;
            r5_l_ajck <= PL_W'(r4_aj * ck_lo);
            r5_l_akcj <= PL_W'(r4_ak * cj_lo);
            r5_l_cjbk <= PL_W'(r4_bk * cj_lo);
            r5_l_ckbj <= PL_W'(r4_bj * ck_lo);
            r5_h_ajck <= PH_W'(r4_aj * ck_hi);
            r5_h_akcj <= PH_W'(r4_ak * cj_hi);
            r5_h_cjbk <= PH_W'(r4_bk * cj_hi);
            r5_h_ckbj <= PH_W'(r4_bj * ck_hi);
        end
    end

    // --------------------------------------------------------------------
    // stage 6: join partial products, tolerance product, |det|
    logic [PP_W-1:0] ajak_mag;
    assign ajak_mag = r5_ajak[PP_W-1] ? PP_W'(-r5_ajak) : PP_W'(r5_ajak);

    logic r6_vld, r6_allx, r6_zero, r6_det_zero, r6_det_neg;
    logic [DET_W-1:0] r6_det_mag;
    logic [TP_W-1:0]  r6_tolprod;
    logic signed [P_W-1:0] r6_ajck, r6_akcj, r6_cjbk, r6_ckbj;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r6_vld <= 1'b0;
        end else if (en) begin
            r6_vld <= r5_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r6_allx     <= r5_allx;
            r6_zero     <= r5_zero;
            r6_det_zero <= (r5_det == '0);
            r6_det_neg  <= r5_det[DET_W-1];
            r6_det_mag  <= r5_det[DET_W-1] ? DET_W'(-r5_det) : DET_W'(r5_det);
            r6_tolprod  <= TP_W'(r_tol) * TP_W'(ajak_mag);
            r6_ajck     <= (P_W'(r5_h_ajck) <<< LO_W) + P_W'(r5_l_ajck);
            r6_akcj     <= (P_W'(r5_h_akcj) <<< LO_W) + P_W'(r5_l_akcj);
            r6_cjbk     <= (P_W'(r5_h_cjbk) <<< LO_W) + P_W'(r5_l_cjbk);
            r6_ckbj     <= (P_W'(r5_h_ckbj) <<< LO_W) + P_W'(r5_l_ckbj);
        end
    end

    // --------------------------------------------------------------------
    // stage 7: numerators and the parallel-lines test
    logic [CMP_W-1:0] lhs, rhs;
    assign lhs = CMP_W'(r6_det_mag) << FRAC_BITS;
    assign rhs = CMP_W'(r6_tolprod);

    logic r7_vld, r7_found, r7_det_neg;
    logic [DET_W-1:0] r7_det_mag;
    logic signed [N_W-1:0] r7_nx, r7_ny;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r7_vld <= 1'b0;
        end else if (en) begin
            r7_vld <= r6_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r7_found   <= !r6_allx && !r6_zero && !r6_det_zero && !(lhs < rhs);
            r7_det_neg <= r6_det_neg;
            r7_det_mag <= r6_det_mag;
            r7_nx      <= N_W'(r6_cjbk) - N_W'(r6_ckbj);
            r7_ny      <= N_W'(r6_ajck) - N_W'(r6_akcj);
        end
    end

    // --------------------------------------------------------------------
    // stage 8: magnitudes and result signs
    logic r8_vld, r8_found, r8_neg_x, r8_neg_y;
    logic [N_W-1:0] r8_nx, r8_ny;
    logic [D_W-1:0] r8_den;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r8_vld <= 1'b0;
        end else if (en) begin
            r8_vld <= r7_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r8_found <= r7_found;
            r8_neg_x <= r7_nx[N_W-1] ^ r7_det_neg;
            r8_neg_y <= r7_ny[N_W-1] ^ r7_det_neg;
            r8_nx    <= r7_nx[N_W-1] ? N_W'(-r7_nx) : N_W'(r7_nx);
            r8_ny    <= r7_ny[N_W-1] ? N_W'(-r7_ny) : N_W'(r7_ny);
            r8_den   <= {r7_det_mag, 1'b0};
        end
    end

    // --------------------------------------------------------------------
    // divider: entry stage checks quotient overflow, then one bit per stage
    logic           r_dv_vld  [DIV_STEPS+1];
    t_side          r_dv_side [DIV_STEPS+1];
    logic [N_W-1:0] r_dv_rx   [DIV_STEPS+1];
    logic [N_W-1:0] r_dv_ry   [DIV_STEPS+1];
    logic [Q_W-1:0] r_dv_qx   [DIV_STEPS+1];
    logic [Q_W-1:0] r_dv_qy   [DIV_STEPS+1];

    logic [N_W-1:0] den_top;
    assign den_top = N_W'(r8_den) << DIV_STEPS;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dv_vld[0] <= 1'b0;
        end else if (en) begin
            r_dv_vld[0] <= r8_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_dv_side[0].found <= r8_found;
            r_dv_side[0].neg_x <= r8_neg_x;
            r_dv_side[0].neg_y <= r8_neg_y;
            r_dv_side[0].ovf_x <= r8_nx >= den_top;
            r_dv_side[0].ovf_y <= r8_ny >= den_top;
            r_dv_side[0].den   <= r8_den;
            r_dv_rx[0]         <= r8_nx;
            r_dv_ry[0]         <= r8_ny;
            r_dv_qx[0]         <= '0;
            r_dv_qy[0]         <= '0;
        end
    end

    for (genvar k = 1; k <= DIV_STEPS; k++) begin : g_div
        localparam int B = DIV_STEPS - k;
        logic [N_W-1:0] dsh;
        logic           gex, gey;

        assign dsh = N_W'(r_dv_side[k-1].den) << B;
        assign gex = r_dv_rx[k-1] >= dsh;
        assign gey = r_dv_ry[k-1] >= dsh;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_dv_vld[k] <= 1'b0;
            end else if (en) begin
                r_dv_vld[k] <= r_dv_vld[k-1];
            end
        end

        always_ff @(posedge i_clk) begin
            if (en) begin
                r_dv_side[k] <= r_dv_side[k-1];
                r_dv_rx[k]   <= gex ? r_dv_rx[k-1] - dsh : r_dv_rx[k-1];
                r_dv_ry[k]   <= gey ? r_dv_ry[k-1] - dsh : r_dv_ry[k-1];
                r_dv_qx[k]   <= r_dv_qx[k-1] | (Q_W'(gex) << B);
                r_dv_qy[k]   <= r_dv_qy[k-1] | (Q_W'(gey) << B);
            end
        end
    end

    // --------------------------------------------------------------------
    // rounding: half away from zero on the magnitude
    logic [N_W:0] rem2x, rem2y, den_ext;
    assign rem2x   = {r_dv_rx[DIV_STEPS], 1'b0};
    assign rem2y   = {r_dv_ry[DIV_STEPS], 1'b0};
    assign den_ext = (N_W+1)'(r_dv_side[DIV_STEPS].den);

    logic r_rnd_vld;
    t_side r_rnd_side;
    logic [Q_W:0] r_rnd_qx, r_rnd_qy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rnd_vld <= 1'b0;
        end else if (en) begin
            r_rnd_vld <= r_dv_vld[DIV_STEPS];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_rnd_side <= r_dv_side[DIV_STEPS];
            r_rnd_qx   <= (Q_W+1)'(r_dv_qx[DIV_STEPS]) + (Q_W+1)'(rem2x >= den_ext);
            r_rnd_qy   <= (Q_W+1)'(r_dv_qy[DIV_STEPS]) + (Q_W+1)'(rem2y >= den_ext);
        end
    end

    // --------------------------------------------------------------------
    // saturate, zero a miss, hand over to the skid
    t_res push_res;
    logic push;

    always_comb begin
        push_res.found = r_rnd_side.found;
        if (r_rnd_side.found) begin
            push_res.x = sat_q(r_rnd_qx, r_rnd_side.neg_x, r_rnd_side.ovf_x);
            push_res.y = sat_q(r_rnd_qy, r_rnd_side.neg_y, r_rnd_side.ovf_y);
        end else begin
            push_res.x = '0;
            push_res.y = '0;
        end
    end

    assign push = r_rnd_vld && en;

    // output register plus spare; the spare only fills when the receiver stalls
    t_res r_out, r_spare;
    logic r_out_vld;
    logic pop;

    assign pop = r_out_vld && i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld   <= 1'b0;
            r_spare_vld <= 1'b0;
        end else if (r_spare_vld) begin
            if (pop) begin
                r_out       <= r_spare;
                r_spare_vld <= 1'b0;
            end
        end else if (push) begin
            if (!r_out_vld || pop) begin
                r_out     <= push_res;
                r_out_vld <= 1'b1;
            end else begin
                r_spare     <= push_res;
                r_spare_vld <= 1'b1;
            end
        end else if (pop) begin
            r_out_vld <= 1'b0;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_found     = r_out.found;
    assign o_target_x  = r_out.x;
    assign o_target_y  = r_out.y;

endmodule

// ===== design/tri_checker.sv =====
module tri_checker
    import tri_pkg::*;
(
    input logic   i_clk,
    input logic   i_rst_n,
    input logic   i_in_valid,
    input logic   o_in_ready,
    input logic   o_out_valid,
    input logic   i_out_ready,
    input logic   o_found,
    input t_coord o_target_x,
    input t_coord o_target_y
);

    // a miss always carries a zero position
    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_found |-> o_target_x == '0 && o_target_y == '0)
        else $error("not-found beat with nonzero position");

    // input backpressure only when an output beat is waiting
    a_bp_needs_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> o_out_valid)
        else $error("input stalled with empty output");

    // reset empties the output
    a_rst_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && o_in_ready)
        else $error("output valid after reset");

    // a stalled output beat holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_found)
            && $stable(o_target_x) && $stable(o_target_y))
        else $error("output beat changed while stalled");

    // an offered input beat stays offered until taken
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_ready |=> i_in_valid)
        else $error("input beat withdrawn before accept");

endmodule

bind three_circle_trilateration tri_checker u_tri_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_found     (o_found),
    .o_target_x  (o_target_x),
    .o_target_y  (o_target_y)
);
